// ----- rtl/core/key_value_line_parser_unit_assert.svh -----
// ---------------------------------------------------------------------------
// key/value line parser assertion macros
// clocked on clk, disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef KEY_VALUE_LINE_PARSER_UNIT_ASSERT_SVH
`define KEY_VALUE_LINE_PARSER_UNIT_ASSERT_SVH

// same-cycle implication
`define KVLP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KVLP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/kvlp_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// kvlp_pkg
// shared character codes, state encodings and inter-module structs
// ---------------------------------------------------------------------------
package kvlp_pkg;

  // character codes
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  // line scanner phase
  typedef enum logic [4:0] {
    PH_LEAD  = 5'b00001,
    PH_KEY   = 5'b00010,
    PH_VLEAD = 5'b00100,
    PH_VAL   = 5'b01000,
    PH_SKIP  = 5'b10000
  } kvlp_phase_t;

  // drain sequencer state
  typedef enum logic [2:0] {
    DR_IDLE = 3'b001,
    DR_KEY  = 3'b010,
    DR_VAL  = 3'b100
  } kvlp_drain_st_t;

  // store write controls
  typedef struct packed {
    logic       key_we;
    logic       val_we;
    logic [7:0] data;
  } kvlp_wr_t;

  // store read controls
  typedef struct packed {
    logic rd_en;
  } kvlp_rd_t;

  // tags travelling with a pending read
  typedef struct packed {
    logic in_value;
    logic pair_end;
  } kvlp_meta_t;

endpackage
`default_nettype wire

// ----- rtl/core/kvlp_pair_store.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// kvlp_pair_store
// key and value byte memories, one write port each, shared registered read
// ---------------------------------------------------------------------------
module kvlp_pair_store
  import kvlp_pkg::*;
#(
  parameter int DEPTH = 31,
  parameter int IDX_W = 5
) (
  input  wire logic             clk,
  input  wire kvlp_wr_t         wr,
  input  wire logic [IDX_W-1:0] key_waddr,
  input  wire logic [IDX_W-1:0] val_waddr,
  input  wire kvlp_rd_t         rd,
  input  wire logic [IDX_W-1:0] rd_addr,
  output logic      [7:0]       key_q,
  output logic      [7:0]       val_q
);

  logic [7:0] key_mem [DEPTH];
  logic [7:0] val_mem [DEPTH];

  // key memory
  always_ff @(posedge clk) begin
    if (wr.key_we) begin
      key_mem[key_waddr] <= wr.data;
    end
    if (rd.rd_en) begin
      key_q <= key_mem[rd_addr];
    end
  end

  // value memory
  always_ff @(posedge clk) begin
    if (wr.val_we) begin
      val_mem[val_waddr] <= wr.data;
    end
    if (rd.rd_en) begin
      val_q <= val_mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/kvlp_line_fsm.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// kvlp_line_fsm
// per-byte line scanner: classifies the line, writes key and value bytes
// into the store and decides at line end whether a pair is to be emitted
// ---------------------------------------------------------------------------
module kvlp_line_fsm
  import kvlp_pkg::*;
#(
  parameter int MAX_LINE = 32,
  parameter int CNT_W    = 6,
  parameter int IDX_W    = 5
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             byte_acc,
  input  wire logic [7:0]       text_byte,
  input  wire logic             buffer_end,
  output kvlp_wr_t              wr,
  output logic      [IDX_W-1:0] key_waddr,
  output logic      [IDX_W-1:0] val_waddr,
  output logic                  start,
  output logic      [CNT_W-1:0] klen,
  output logic      [CNT_W-1:0] vlen
);

  localparam logic [CNT_W-1:0] MAXL    = CNT_W'(MAX_LINE);
  localparam logic [CNT_W-1:0] MAXL_M1 = CNT_W'(MAX_LINE - 1);

  kvlp_phase_t      phase_r, phase_nxt;
  logic [7:0]       first_r, first_nxt;
  logic [7:0]       last_r, last_nxt;
  logic             slash_r, slash_nxt;
  logic [CNT_W-1:0] key_cnt_r, key_cnt_nxt;
  logic [CNT_W-1:0] key_vis_r, key_vis_nxt;
  logic [CNT_W-1:0] val_cnt_r, val_cnt_nxt;
  logic [CNT_W-1:0] val_vis_r, val_vis_nxt;

  logic is_nl, is_blank, is_trim, do_key, do_val, eol;

  assign is_nl    = (text_byte == CH_LF);
  assign is_blank = (text_byte == CH_SP) || (text_byte == CH_TAB);
  assign is_trim  = is_blank || (text_byte == CH_CR) || is_nl;
  assign eol      = byte_acc && (is_nl || buffer_end);

  assign key_waddr = key_cnt_r[IDX_W-1:0];
  assign val_waddr = val_cnt_r[IDX_W-1:0];

  // byte consumption, pair decision and line reset
  always_comb begin
    phase_nxt   = phase_r;
    first_nxt   = first_r;
    last_nxt    = last_r;
    slash_nxt   = slash_r;
    key_cnt_nxt = key_cnt_r;
    key_vis_nxt = key_vis_r;
    val_cnt_nxt = val_cnt_r;
    val_vis_nxt = val_vis_r;
    do_key      = 1'b0;
    do_val      = 1'b0;
    wr          = '0;
    wr.data     = text_byte;

    if (byte_acc && !is_nl) begin
      unique case (phase_r)
        PH_LEAD: begin
          if (!is_blank) begin
            first_nxt = text_byte;
            if (!is_trim) begin
              last_nxt = text_byte;
            end
            if (text_byte == CH_HASH || text_byte == CH_SEMI) begin
              phase_nxt = PH_SKIP;
            end else if (text_byte == CH_EQ) begin
              phase_nxt = PH_VLEAD;
            end else begin
              phase_nxt = PH_KEY;
              slash_nxt = (text_byte == CH_SLASH);
              do_key    = 1'b1;
            end
          end
        end
        PH_KEY: begin
          slash_nxt = 1'b0;
          if (slash_r && text_byte == CH_SLASH) begin
            phase_nxt = PH_SKIP;
          end else if (text_byte == CH_EQ) begin
            last_nxt  = text_byte;
            phase_nxt = PH_VLEAD;
          end else begin
            do_key = 1'b1;
          end
        end
        PH_VLEAD: begin
          if (!is_blank) begin
            phase_nxt = PH_VAL;
            do_val    = 1'b1;
          end
        end
        PH_VAL: begin
          do_val = 1'b1;
        end
        PH_SKIP: begin
        end
        default: begin
          phase_nxt = PH_LEAD;
        end
      endcase
    end

    // key byte: store while room, count saturating
    if (do_key) begin
      wr.key_we = (key_cnt_r < MAXL_M1);
      if (key_cnt_r < MAXL) begin
        key_cnt_nxt = key_cnt_r + CNT_W'(1);
      end
      if (!is_trim) begin
        key_vis_nxt = key_cnt_nxt;
        last_nxt    = text_byte;
      end
    end

    // value byte
    if (do_val) begin
      wr.val_we = (val_cnt_r < MAXL_M1);
      if (val_cnt_r < MAXL) begin
        val_cnt_nxt = val_cnt_r + CNT_W'(1);
      end
      if (!is_trim) begin
        val_vis_nxt = val_cnt_nxt;
        last_nxt    = text_byte;
      end
    end

    // pair decision on the state left by the closing byte
    start = eol
            && (phase_nxt == PH_VLEAD || phase_nxt == PH_VAL)
            && !(first_nxt == CH_LBRACK && last_nxt == CH_RBRACK)
            && (key_vis_nxt != '0) && (key_vis_nxt < MAXL);
    klen  = key_vis_nxt;
    vlen  = (val_vis_nxt > MAXL_M1) ? MAXL_M1 : val_vis_nxt;

    // fresh line
    if (eol) begin
      phase_nxt   = PH_LEAD;
      first_nxt   = '0;
      last_nxt    = '0;
      slash_nxt   = 1'b0;
      key_cnt_nxt = '0;
      key_vis_nxt = '0;
      val_cnt_nxt = '0;
      val_vis_nxt = '0;
    end
  end

  // line state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_LEAD;
      first_r   <= '0;
      last_r    <= '0;
      slash_r   <= 1'b0;
      key_cnt_r <= '0;
      key_vis_r <= '0;
      val_cnt_r <= '0;
      val_vis_r <= '0;
    end else begin
      phase_r   <= phase_nxt;
      first_r   <= first_nxt;
      last_r    <= last_nxt;
      slash_r   <= slash_nxt;
      key_cnt_r <= key_cnt_nxt;
      key_vis_r <= key_vis_nxt;
      val_cnt_r <= val_cnt_nxt;
      val_vis_r <= val_vis_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/kvlp_drain.sv -----
`default_nettype none
`include "key_value_line_parser_unit_assert.svh"
// ---------------------------------------------------------------------------
// kvlp_drain
// reads the stored key then value bytes of an accepted pair and presents
// them through the output register
// ---------------------------------------------------------------------------
module kvlp_drain
  import kvlp_pkg::*;
#(
  parameter int CNT_W = 6,
  parameter int IDX_W = 5
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [CNT_W-1:0] klen,
  input  wire logic [CNT_W-1:0] vlen,
  input  wire logic [7:0]       key_q,
  input  wire logic [7:0]       val_q,
  output kvlp_rd_t              rd,
  output logic      [IDX_W-1:0] rd_addr,
  output logic                  busy,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic      [7:0]       out_byte,
  output logic                  out_in_value,
  output logic                  out_pair_end
);

  kvlp_drain_st_t   st_r, st_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt, idx_inc;
  logic [CNT_W-1:0] klen_r, klen_nxt;
  logic [CNT_W-1:0] vlen_r, vlen_nxt;
  logic             pend_r;
  kvlp_meta_t       meta_r, meta_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  kvlp_meta_t       out_meta_r, out_meta_nxt;
  logic             issue;

  assign busy    = (st_r != DR_IDLE);
  assign issue   = busy && !pend_r && (!out_valid_r || !out_stall);
  assign idx_inc = idx_r + CNT_W'(1);
  assign rd_addr = idx_r[IDX_W-1:0];
  assign rd.rd_en = issue;

  // read sequencer: key bytes, then value bytes
  always_comb begin
    st_nxt   = st_r;
    idx_nxt  = idx_r;
    klen_nxt = klen_r;
    vlen_nxt = vlen_r;
    meta_nxt = meta_r;
    unique case (st_r)
      DR_IDLE: begin
        if (start) begin
          klen_nxt = klen;
          vlen_nxt = vlen;
          idx_nxt  = '0;
          st_nxt   = DR_KEY;
        end
      end
      DR_KEY: begin
        if (issue) begin
          meta_nxt.in_value = 1'b0;
          meta_nxt.pair_end = (vlen_r == '0) && (idx_inc == klen_r);
          if (idx_inc == klen_r) begin
            idx_nxt = '0;
            st_nxt  = (vlen_r == '0) ? DR_IDLE : DR_VAL;
          end else begin
            idx_nxt = idx_inc;
          end
        end
      end
      DR_VAL: begin
        if (issue) begin
          meta_nxt.in_value = 1'b1;
          meta_nxt.pair_end = (idx_inc == vlen_r);
          if (idx_inc == vlen_r) begin
            idx_nxt = '0;
            st_nxt  = DR_IDLE;
          end else begin
            idx_nxt = idx_inc;
          end
        end
      end
      default: begin
        st_nxt = DR_IDLE;
      end
    endcase
  end

  // output register, loaded from the store data in the cycle after the read is issued
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_meta_nxt  = out_meta_r;
    if (pend_r) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = meta_r.in_value ? val_q : key_q;
      out_meta_nxt  = meta_r;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= DR_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      pend_r      <= issue;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    klen_r     <= klen_nxt;
    vlen_r     <= vlen_nxt;
    meta_r     <= meta_nxt;
    out_byte_r <= out_byte_nxt;
    out_meta_r <= out_meta_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_in_value = out_meta_r.in_value;
  assign out_pair_end = out_meta_r.pair_end;

  // checks
  `KVLP_ASSERT_IMP(a_start_when_idle, start, st_r == DR_IDLE, "pair closed while draining")
  `KVLP_ASSERT_IMP(a_start_key_nonempty, start, klen != '0, "pair started with empty key")
  `KVLP_ASSERT_IMP(a_pend_out_free, pend_r, !out_valid_r, "read data due with output full")
  `KVLP_ASSERT_NXT(a_start_drains, start, st_r == DR_KEY, "pair start did not begin drain")

endmodule
`default_nettype wire

// ----- rtl/core/key_value_line_parser_unit.sv -----
// a line-closing item that yields a pair starts a drain of its bytes to the output register
// input items are taken as offered while a line is being scanned
// input is held off while a pair drains: one store read per output byte, the next read
// issued only once the previous read data has landed
// reset: synchronous active-low rst_n clears line and drain state; no memory clearing pass
`default_nettype none
// ---------------------------------------------------------------------------
// key_value_line_parser_unit
// splits byte text into lines and emits key and value bytes of each
// key=value line, skipping blanks, comments and section headers
// ---------------------------------------------------------------------------
module key_value_line_parser_unit
  import kvlp_pkg::*;
#(
  parameter int MAX_LINE = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_text_byte,
  input  wire logic       in_buffer_end,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic      [7:0] out_byte,
  output logic            out_in_value,
  output logic            out_pair_end
);

  localparam int CNT_W = $clog2(MAX_LINE + 1);
  localparam int DEPTH = MAX_LINE - 1;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  kvlp_wr_t         wr;
  kvlp_rd_t         rd;
  logic [IDX_W-1:0] key_waddr, val_waddr, rd_addr;
  logic [CNT_W-1:0] klen, vlen;
  logic [7:0]       key_q, val_q;
  logic             start, busy, byte_acc;

  // input held off while a pair drains, so store writes never meet reads
  assign in_stall = busy;
  assign byte_acc = in_valid && !in_stall;

  // line scanner
  kvlp_line_fsm #(
    .MAX_LINE (MAX_LINE),
    .CNT_W    (CNT_W),
    .IDX_W    (IDX_W)
  ) u_line (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_acc   (byte_acc),
    .text_byte  (in_text_byte),
    .buffer_end (in_buffer_end),
    .wr         (wr),
    .key_waddr  (key_waddr),
    .val_waddr  (val_waddr),
    .start      (start),
    .klen       (klen),
    .vlen       (vlen)
  );

  // key and value byte memories
  kvlp_pair_store #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_store (
    .clk       (clk),
    .wr        (wr),
    .key_waddr (key_waddr),
    .val_waddr (val_waddr),
    .rd        (rd),
    .rd_addr   (rd_addr),
    .key_q     (key_q),
    .val_q     (val_q)
  );

  // pair drain and output register
  kvlp_drain #(
    .CNT_W (CNT_W),
    .IDX_W (IDX_W)
  ) u_drain (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .klen         (klen),
    .vlen         (vlen),
    .key_q        (key_q),
    .val_q        (val_q),
    .rd           (rd),
    .rd_addr      (rd_addr),
    .busy         (busy),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_in_value (out_in_value),
    .out_pair_end (out_pair_end)
  );

endmodule
`default_nettype wire

// ----- bench/tb_key_value_line_parser_unit.sv -----
// ----------------------------------------------------------------------------
// tb_key_value_line_parser_unit
// feeds text bytes to the key/value line parser and checks every emitted key
// and value byte against a behavioural model of the line scanner, or against the
// key and value of a typed table row. A short table of hand-picked lines comes first,
// then random lines, with random input gaps and output stalls that stop near the end of the run
// ----------------------------------------------------------------------------
module tb_key_value_line_parser_unit
  import kvlp_pkg::*;
();

  localparam int MAX_LINE     = 32;
  localparam int RANDOM_BYTES = 24;
  localparam int QUIET_LIMIT  = 2000;
  localparam int REPORT_CAP   = 200;

  // one emitted byte of a pair
  typedef struct packed {
    logic [7:0] data;
    logic       val_part;
    logic       last_of_pair;
  } kv_byte_t;

  // one hand-picked line; kpad puts that many 'k' bytes in front of txt
  typedef struct {
    string txt;
    int    kpad;
    bit    eob;
    bit    typed;
    string ekey;
    string evalue;
  } line_case_t;

  logic       clk           = 1'b0;
  logic       rst_n         = 1'b0;
  logic       in_valid      = 1'b0;
  logic [7:0] in_text_byte  = 8'h00;
  logic       in_buffer_end = 1'b0;
  logic       out_stall     = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_in_value;
  logic       out_pair_end;

  // line scanner model state
  kvlp_phase_t scan_ph;
  logic [7:0]  head_chr;
  logic [7:0]  tail_chr;
  bit          slash_seen;
  logic [7:0]  key_buf [MAX_LINE-1];
  logic [7:0]  val_buf [MAX_LINE-1];
  int          key_len, key_vis, val_len, val_vis;

  kv_byte_t pair_bytes_q[$];
  bit       table_owns_exp = 1'b0;
  int       idle_mode      = 0;
  int       stall_left     = 0;
  int       quiet_cycles   = 0;
  int       errors         = 0;
  int       bytes_in       = 0;
  int       bytes_out      = 0;
  int       pairs_out      = 0;
  int       lines_closed   = 0;
  int       pairs_predicted = 0;

  // hand-picked lines; typed rows carry their own key and value, \001 stands for NUL,
  // \015 is a carriage return
  line_case_t line_tab[$] = '{
    '{"a=b\n",                  0,  1'b0, 1'b1, "a",    "b"},
    '{"  \tkey \t=\t value \015\n", 0, 1'b0, 1'b1, "key",  "value"},
    '{"\n",                     0,  1'b0, 1'b1, "",     ""},
    '{" \t \015\n",             0,  1'b0, 1'b1, "",     ""},
    '{"# c=1\n",                0,  1'b0, 1'b1, "",     ""},
    '{"; c=1\n",                0,  1'b0, 1'b1, "",     ""},
    '{"// c=1\n",               0,  1'b0, 1'b1, "",     ""},
    '{"/k=1\n",                 0,  1'b0, 1'b1, "/k",   "1"},
    '{"[sec]\n",                0,  1'b0, 1'b1, "",     ""},
    '{"[a=b]\n",                0,  1'b0, 1'b1, "",     ""},
    '{"[a=b\n",                 0,  1'b0, 1'b1, "[a",   "b"},
    '{"noequals\n",             0,  1'b0, 1'b1, "",     ""},
    '{"=v\n",                   0,  1'b0, 1'b1, "",     ""},
    '{" \015=v\n",              0,  1'b0, 1'b1, "",     ""},
    '{"k=\n",                   0,  1'b0, 1'b1, "k",    ""},
    '{"k=  \t\n",               0,  1'b0, 1'b1, "k",    ""},
    '{"a\015b=c\015",           0,  1'b1, 1'b1, "a\015b", "c"},
    '{"x=y\n",                  0,  1'b1, 1'b1, "x",    "y"},
    '{"\001k\001=\001v\001\n",  0,  1'b0, 1'b0, "",     ""},
    '{"\377=\377\n",            0,  1'b0, 1'b1, "\377", "\377"},
    '{"=1\n",                   31, 1'b0, 1'b0, "",     ""},
    '{"=1\n",                   32, 1'b0, 1'b1, "",     ""},
    '{" \t=1\n",                34, 1'b0, 1'b1, "",     ""},
    '{"v=0123456789abcdefghijklmnopqrstuvwx\n", 0, 1'b0, 1'b0, "", ""},
    '{"a==b\n",                 0,  1'b0, 1'b1, "a",    "=b"},
    '{"k = v v\n",              0,  1'b0, 1'b1, "k",    "v v"}
  };

  key_value_line_parser_unit #(
    .MAX_LINE(MAX_LINE)
  ) DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_text_byte (in_text_byte),
    .in_buffer_end(in_buffer_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_in_value (out_in_value),
    .out_pair_end (out_pair_end)
  );

  always #1 clk = ~clk;

  function automatic bit blank_chr(input logic [7:0] b);
    return b == CH_SP || b == CH_TAB;
  endfunction

  function automatic bit trim_chr(input logic [7:0] b);
    return blank_chr(b) || b == CH_CR || b == CH_LF;
  endfunction

  // random key or value byte, never '=' or newline
  function automatic logic [7:0] text_chr(input bit wide);
    logic [7:0] c;
    do begin
      c = wide ? 8'($urandom_range(0, 255)) : 8'($urandom_range(8'h21, 8'h7E));
    end while (c == CH_EQ || c == CH_LF);
    return c;
  endfunction

  task automatic clear_line();
    scan_ph    = PH_LEAD;
    head_chr   = 8'h00;
    tail_chr   = 8'h00;
    slash_seen = 1'b0;
    key_len    = 0;
    key_vis    = 0;
    val_len    = 0;
    val_vis    = 0;
  endtask

  // counts saturate at MAX_LINE, only the first MAX_LINE-1 bytes are kept
  task automatic add_key_chr(input logic [7:0] b);
    if (key_len < MAX_LINE - 1) key_buf[key_len] = b;
    if (key_len < MAX_LINE) key_len++;
    if (!trim_chr(b)) begin
      key_vis  = key_len;
      tail_chr = b;
    end
  endtask

  task automatic add_val_chr(input logic [7:0] b);
    if (val_len < MAX_LINE - 1) val_buf[val_len] = b;
    if (val_len < MAX_LINE) val_len++;
    if (!trim_chr(b)) begin
      val_vis  = val_len;
      tail_chr = b;
    end
  endtask

  task automatic scan_chr(input logic [7:0] b);
    case (scan_ph)
      PH_LEAD: begin
        if (!blank_chr(b)) begin
          head_chr = b;
          if (!trim_chr(b)) tail_chr = b;
          if (b == CH_HASH || b == CH_SEMI) begin
            scan_ph = PH_SKIP;
          end else if (b == CH_EQ) begin
            scan_ph = PH_VLEAD;
          end else begin
            scan_ph    = PH_KEY;
            slash_seen = (b == CH_SLASH);
            add_key_chr(b);
          end
        end
      end
      PH_KEY: begin
        // a second slash straight after a leading one makes a comment
        if (slash_seen && b == CH_SLASH) begin
          scan_ph = PH_SKIP;
        end else if (b == CH_EQ) begin
          tail_chr = b;
          scan_ph  = PH_VLEAD;
        end else begin
          add_key_chr(b);
        end
        slash_seen = 1'b0;
      end
      PH_VLEAD: begin
        if (!blank_chr(b)) begin
          scan_ph = PH_VAL;
          add_val_chr(b);
        end
      end
      PH_VAL: add_val_chr(b);
      default: ;
    endcase
  endtask

  // end of line: queue the key bytes, then the value bytes
  task automatic close_line();
    int       vlen;
    kv_byte_t o;
    lines_closed++;
    if ((scan_ph == PH_VLEAD || scan_ph == PH_VAL) &&
        !(head_chr == CH_LBRACK && tail_chr == CH_RBRACK) &&
        key_vis != 0 && key_vis < MAX_LINE) begin
      vlen = (val_vis > MAX_LINE - 1) ? MAX_LINE - 1 : val_vis;
      pairs_predicted++;
      for (int i = 0; i < key_vis; i++) begin
        o = '{key_buf[i], 1'b0, vlen == 0 && i + 1 == key_vis};
        if (!table_owns_exp) pair_bytes_q.push_back(o);
      end
      for (int i = 0; i < vlen; i++) begin
        o = '{val_buf[i], 1'b1, i + 1 == vlen};
        if (!table_owns_exp) pair_bytes_q.push_back(o);
      end
    end
  endtask

  task automatic predict_text_byte(input logic [7:0] b, input bit eob);
    if (b != CH_LF) scan_chr(b);
    if (b == CH_LF || eob) begin
      close_line();
      clear_line();
    end
  endtask

  // offer one text byte, with an optional gap first, and wait for it to be taken
  task automatic send_byte(input logic [7:0] b, input bit eob);
    int gap;
    if (idle_mode != 0 && $urandom_range(0, idle_mode == 1 ? 7 : 2) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_text_byte  <= b;
    in_buffer_end <= eob;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_in++;
    predict_text_byte(b, eob);
  endtask

  // output check and stall bursts
  always @(posedge clk) begin
    kv_byte_t want;
    if (rst_n && out_valid && !out_stall) begin
      bytes_out++;
      if (out_pair_end) pairs_out++;
      if (pair_bytes_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t: unexpected output item byte=%h in_value=%b pair_end=%b",
                   $time, out_byte, out_in_value, out_pair_end);
      end else begin
        want = pair_bytes_q.pop_front();
        if (out_byte !== want.data) begin
          errors++;
          if (errors <= REPORT_CAP)
            $display("%0t: out_byte expected %h actual %h", $time, want.data, out_byte);
        end
        if (out_in_value !== want.val_part) begin
          errors++;
          if (errors <= REPORT_CAP)
            $display("%0t: out_in_value expected %b actual %b",
                     $time, want.val_part, out_in_value);
        end
        if (out_pair_end !== want.last_of_pair) begin
          errors++;
          if (errors <= REPORT_CAP)
            $display("%0t: out_pair_end expected %b actual %b",
                     $time, want.last_of_pair, out_pair_end);
        end
      end
    end
    // out_stall always drops after a burst before another burst can begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (out_stall) begin
      out_stall <= 1'b0;
    end else if (idle_mode != 0 && $urandom_range(0, idle_mode == 1 ? 7 : 2) == 0) begin
      stall_left = $urandom_range(0, 7);
      out_stall <= 1'b1;
    end
  end

  // watchdog on cycles where no item moves on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no item moved for %0d cycles, %0d output items still owed",
               $time, quiet_cycles, pair_bytes_q.size());
      $display("tb_key_value_line_parser_unit: errors");
      $finish;
    end
  end

  initial begin
    line_case_t row;
    string      txt;
    logic [7:0] b;
    kv_byte_t   o;
    logic [7:0] lq[$];
    int         kind, n, dir_bytes;
    bit         wide, eob_end, noise_line;

    clear_line();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // hand-picked lines
    idle_mode = 1;
    foreach (line_tab[r]) begin
      row = line_tab[r];
      if (row.typed) begin
        for (int i = 0; i < row.ekey.len(); i++) begin
          o = '{row.ekey[i], 1'b0, row.evalue.len() == 0 && i + 1 == row.ekey.len()};
          pair_bytes_q.push_back(o);
        end
        for (int i = 0; i < row.evalue.len(); i++) begin
          o = '{row.evalue[i], 1'b1, i + 1 == row.evalue.len()};
          pair_bytes_q.push_back(o);
        end
      end
      table_owns_exp = row.typed;
      txt = "";
      for (int j = 0; j < row.kpad; j++) txt = {txt, "k"};
      txt = {txt, row.txt};
      for (int i = 0; i < txt.len(); i++) begin
        b = txt[i];
        if (b == 8'h01) b = 8'h00;
        send_byte(b, row.eob && i == txt.len() - 1);
      end
    end
    table_owns_exp = 1'b0;
    dir_bytes = bytes_in;

    // random lines, mostly well-formed pairs
    while (bytes_in - dir_bytes < RANDOM_BYTES) begin
      idle_mode = (bytes_in - dir_bytes > RANDOM_BYTES * 4 / 5) ? 0 : $urandom_range(0, 2);
      lq.delete();
      wide       = ($urandom_range(0, 3) == 0);
      eob_end    = 1'b0;
      noise_line = 1'b0;
      kind       = $urandom_range(0, 99);
      if (kind < 60) begin
        repeat ($urandom_range(0, 2)) lq.push_back($urandom_range(0, 1) ? CH_SP : CH_TAB);
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(28, 34) : $urandom_range(1, 6);
        lq.push_back(8'($urandom_range(8'h61, 8'h7A)));
        repeat (n - 1) lq.push_back(text_chr(wide));
        repeat ($urandom_range(0, 2)) lq.push_back($urandom_range(0, 1) ? CH_SP : CH_TAB);
        lq.push_back(CH_EQ);
        repeat ($urandom_range(0, 2)) lq.push_back($urandom_range(0, 1) ? CH_SP : CH_TAB);
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 36) : $urandom_range(0, 8);
        repeat (n) lq.push_back(text_chr(wide));
        repeat ($urandom_range(0, 2)) begin
          case ($urandom_range(0, 2))
            0: lq.push_back(CH_SP);
            1: lq.push_back(CH_TAB);
            default: lq.push_back(CH_CR);
          endcase
        end
      end else if (kind < 70) begin
        // comment lines, sometimes holding an '='
        case ($urandom_range(0, 2))
          0: lq.push_back(CH_HASH);
          1: lq.push_back(CH_SEMI);
          default: begin
            lq.push_back(CH_SLASH);
            lq.push_back(CH_SLASH);
          end
        endcase
        lq.push_back(text_chr(wide));
        if ($urandom_range(0, 1)) lq.push_back(CH_EQ);
        repeat ($urandom_range(0, 4)) lq.push_back(text_chr(wide));
      end else if (kind < 78) begin
        lq.push_back(CH_LBRACK);
        repeat ($urandom_range(1, 6)) lq.push_back(text_chr(wide));
        lq.push_back(CH_RBRACK);
        if ($urandom_range(0, 1)) lq.push_back(CH_SP);
      end else if (kind < 85) begin
        repeat ($urandom_range(1, 3)) lq.push_back($urandom_range(0, 1) ? CH_SP : CH_CR);
      end else if (kind < 92) begin
        lq.push_back(8'($urandom_range(8'h61, 8'h7A)));
        repeat ($urandom_range(0, 6)) lq.push_back(text_chr(wide));
      end else begin
        // raw noise, newlines and buffer ends anywhere
        noise_line = 1'b1;
        repeat ($urandom_range(1, 12)) lq.push_back(8'($urandom_range(0, 255)));
      end
      if (!noise_line) begin
        n = $urandom_range(0, 9);
        if (n == 0) begin
          eob_end = 1'b1;
        end else begin
          lq.push_back(CH_LF);
          eob_end = (n == 1);
        end
      end
      foreach (lq[i]) begin
        send_byte(lq[i], noise_line ? ($urandom_range(0, 15) == 0)
                                    : (eob_end && i == lq.size() - 1));
      end
    end
    in_valid <= 1'b0;
    idle_mode = 0;

    // drain, then watch for stray output
    while (pair_bytes_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("run covered %0d text bytes in %0d lines, %0d of them key/value pairs",
             bytes_in, lines_closed, pairs_predicted);
    $display("%0d output items checked over %0d pair ends, %0d mismatches",
             bytes_out, pairs_out, errors);
    if (errors == 0)
      $display("tb_key_value_line_parser_unit: clean");
    else
      $display("tb_key_value_line_parser_unit: errors");
    $finish;
  end

endmodule
